// ===== rtl/ttenc_pkg.sv =====
// Package for the tag tree encoder: item structs, node word, command and
// register codes, state machine types. No dependencies.
package ttenc_pkg;

   localparam int MAX_GRID_WIDTH  = 64;
   localparam int MAX_GRID_HEIGHT = 64;
   localparam int MAX_LEVELS      = 7;
   localparam int NODE_DEPTH      = 5461;
   localparam int NODE_AW         = 13;
   localparam int LVL_W           = 3;
   localparam int DIM_W           = 7;
   localparam int POS_W           = 6;
   localparam int RESULT_CAP      = 63;

   localparam logic [9:0] NODE_INIT = 10'd999;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_ENCODE = 2'd2;

   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;

   typedef logic [NODE_AW-1:0] node_addr_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] leaf_index;
      logic [9:0]  leaf_value;
      logic [5:0]  threshold;
   } req_item_type;

   typedef struct packed {
      logic code_bit;
      logic last_bit;
   } rsp_item_type;

   typedef struct packed {
      logic       known;
      logic [5:0] low;
      logic [9:0] value;
   } node_type;

   typedef enum logic [1:0] {
      P_IDLE,
      P_DIV,
      P_WALK
   } path_state_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RANGE,
      S_PATH,
      S_SET_RD,
      S_SET_CHK,
      S_ENC_RD,
      S_ENC_LOAD,
      S_ENC_BIT,
      S_ENC_WR,
      S_FLUSH
   } core_state_type;

endpackage

// ===== rtl/ttenc_path.sv =====
// Leaf-to-root node address generator: serial divide of the leaf number by
// the grid width, then one tree level per cycle. Uses ttenc_pkg.
module ttenc_path (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [11:0]                    leaf,
   input  logic [ttenc_pkg::DIM_W-1:0]    grid_w,
   input  logic [ttenc_pkg::DIM_W-1:0]    grid_h,
   output logic                           done,
   output logic [ttenc_pkg::LVL_W-1:0]    path_count,
   output ttenc_pkg::node_addr_type       path_list [ttenc_pkg::MAX_LEVELS]
);
   import ttenc_pkg::*;

   path_state_type     state_ff, state_in;
   logic [11:0]        quo_ff, quo_in;
   logic [DIM_W-1:0]   rem_ff, rem_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [DIM_W-1:0]   pw_ff, pw_in, ph_ff, ph_in;
   logic [POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   node_addr_type      off_ff, off_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [LVL_W-1:0]   count_ff;
   node_addr_type      path_ff [MAX_LEVELS];
   logic [DIM_W:0]     trial;
   logic               trial_ge;
   node_addr_type      idx;
   logic               stop;

   assign trial    = {rem_ff, quo_ff[11]};
   assign trial_ge = trial >= {1'b0, grid_w};
   assign idx      = off_ff + NODE_AW'(py_ff) * NODE_AW'(pw_ff) + NODE_AW'(px_ff);
   assign stop     = (pw_ff == DIM_W'(1) && ph_ff == DIM_W'(1))
                     || lvl_ff == LVL_W'(MAX_LEVELS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE: if (start) state_in = P_DIV;
         P_DIV:  if (cnt_ff == 4'd11) state_in = P_WALK;
         P_WALK: if (stop) state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      pw_in  = pw_ff;
      ph_in  = ph_ff;
      px_in  = px_ff;
      py_in  = py_ff;
      off_in = off_ff;
      lvl_in = lvl_ff;
      done   = 1'b0;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               quo_in = leaf;
               rem_in = '0;
               cnt_in = '0;
               pw_in  = grid_w;
               ph_in  = grid_h;
               off_in = '0;
               lvl_in = '0;
            end
         end
         P_DIV: begin
            rem_in = trial_ge ? DIM_W'(trial - {1'b0, grid_w}) : DIM_W'(trial);
            quo_in = {quo_ff[10:0], trial_ge};
            cnt_in = cnt_ff + 4'd1;
            px_in  = rem_in[POS_W-1:0];
            py_in  = quo_in[POS_W-1:0];
         end
         P_WALK: begin
            if (stop) begin
               done = 1'b1;
            end else begin
               off_in = off_ff + NODE_AW'(pw_ff) * NODE_AW'(ph_ff);
               pw_in  = DIM_W'(({1'b0, pw_ff} + 8'd1) >> 1);
               ph_in  = DIM_W'(({1'b0, ph_ff} + 8'd1) >> 1);
               px_in  = px_ff >> 1;
               py_in  = py_ff >> 1;
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      pw_ff  <= pw_in;
      ph_ff  <= ph_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      off_ff <= off_in;
      lvl_ff <= lvl_in;
      if (state_ff == P_WALK) begin
         path_ff[lvl_ff] <= idx;
         if (stop) count_ff <= lvl_ff + LVL_W'(1);
      end
   end

   assign path_count = (state_ff == P_WALK && stop) ? lvl_ff + LVL_W'(1) : count_ff;
   assign path_list  = path_ff;

endmodule

// ===== rtl/tag_tree_encoder_core.sv =====
// Tag tree encoder top level: command sequencer, node memory, result stage.
// Depends on ttenc_pkg and ttenc_path.
//
// Node state sits in one 5461-entry memory with a registered read port,
// holding value, lower bound and known flag per node. After reset and after
// every clear command a clearing pass writes all 5461 entries, one entry
// per cycle, during which req_ready is low; csr writes are taken at any
// time. A set or encode item first checks the leaf against the grid, then
// divides the leaf number by the grid width and forms the node address of
// each tree level (up to 7). Set then lowers node values from the leaf up
// until one holds a value no greater than the new one; encode walks from
// the root down, reading each node, stepping the running bound and writing
// it back, then releases the last bit, and can stall while rsp_ready is low.
// Bits leave through a one-item output register at most one per cycle.
module tag_tree_encoder_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ttenc_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ttenc_pkg::rsp_item_type rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [6:0]              csr_wdata
);
   import ttenc_pkg::*;

   core_state_type    state_ff, state_in;
   logic [DIM_W-1:0]  grid_w_ff, grid_h_ff, w_eff, h_eff;
   logic [1:0]        cmd_ff;
   logic [11:0]       leaf_ff;
   logic [9:0]        val_ff;
   logic [5:0]        thr_ff;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [5:0]        low_ff, low_in;
   logic [9:0]        nv_ff, nv_in;
   logic              nk_ff, nk_in;
   logic              hold_v_ff, hold_v_in, hold_bit_ff, hold_bit_in;
   logic [5:0]        cnt_ff, cnt_in;
   node_addr_type     clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   node_type          node_mem [NODE_DEPTH];
   node_type          rd_data_ff;
   logic              mem_re, mem_we;
   node_addr_type     mem_raddr, mem_waddr;
   node_type          mem_wdata;

   logic              path_start, path_done;
   logic [LVL_W-1:0]  path_count;
   node_addr_type     path_list [MAX_LEVELS];

   logic              accept, out_free, lt, ge, want, stall, node_done, emit_bit;
   logic [5:0]        low_max;

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign w_eff = (grid_w_ff == '0) ? DIM_W'(1) :
                  (grid_w_ff > DIM_W'(MAX_GRID_WIDTH)) ? DIM_W'(MAX_GRID_WIDTH) : grid_w_ff;
   assign h_eff = (grid_h_ff == '0) ? DIM_W'(1) :
                  (grid_h_ff > DIM_W'(MAX_GRID_HEIGHT)) ? DIM_W'(MAX_GRID_HEIGHT) : grid_h_ff;

   assign path_start = state_ff == S_RANGE
                       && {1'b0, leaf_ff} < NODE_AW'(w_eff) * NODE_AW'(h_eff);

   ttenc_path u_path (
      .clock      (clock),
      .reset      (reset),
      .start      (path_start),
      .leaf       (leaf_ff),
      .grid_w     (w_eff),
      .grid_h     (h_eff),
      .done       (path_done),
      .path_count (path_count),
      .path_list  (path_list)
   );

   assign low_max   = (rd_data_ff.low > low_ff) ? rd_data_ff.low : low_ff;
   assign lt        = low_ff < thr_ff;
   assign ge        = {4'b0, low_ff} >= nv_ff;
   assign emit_bit  = ge;
   assign want      = lt && !(ge && nk_ff) && cnt_ff != 6'(RESULT_CAP);
   assign stall     = want && hold_v_ff && !out_free;
   assign node_done = !lt || ge;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (clr_addr_ff == NODE_AW'(NODE_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_item.cmd == CMD_CLEAR) state_in = S_CLEAR;
               else if (req_item.cmd == CMD_SET || req_item.cmd == CMD_ENCODE)
                  state_in = S_RANGE;
            end
         end
         S_RANGE:    state_in = path_start ? S_PATH : S_IDLE;
         S_PATH: begin
            if (path_done) state_in = (cmd_ff == CMD_SET) ? S_SET_RD : S_ENC_RD;
         end
         S_SET_RD:   state_in = S_SET_CHK;
         S_SET_CHK: begin
            if (rd_data_ff.value <= val_ff || lvl_ff + LVL_W'(1) == path_count)
               state_in = S_IDLE;
            else
               state_in = S_SET_RD;
         end
         S_ENC_RD:   state_in = S_ENC_LOAD;
         S_ENC_LOAD: state_in = S_ENC_BIT;
         S_ENC_BIT:  if (!stall && node_done) state_in = S_ENC_WR;
         S_ENC_WR:   state_in = (lvl_ff == '0) ? S_FLUSH : S_ENC_RD;
         S_FLUSH:    if (!hold_v_ff || out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      lvl_in       = lvl_ff;
      low_in       = low_ff;
      nv_in        = nv_ff;
      nk_in        = nk_ff;
      hold_v_in    = hold_v_ff;
      hold_bit_in  = hold_bit_ff;
      cnt_in       = cnt_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      mem_re       = 1'b0;
      mem_raddr    = path_list[lvl_ff];
      mem_we       = 1'b0;
      mem_waddr    = path_list[lvl_ff];
      mem_wdata    = '{known: nk_ff, low: low_ff, value: nv_ff};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '{known: 1'b0, low: '0, value: NODE_INIT};
            clr_addr_in = clr_addr_ff + NODE_AW'(1);
         end
         S_IDLE: begin
            clr_addr_in = '0;
         end
         S_PATH: begin
            lvl_in = (cmd_ff == CMD_SET) ? '0 : path_count - LVL_W'(1);
            low_in = '0;
            cnt_in = '0;
         end
         S_SET_RD: begin
            mem_re = 1'b1;
         end
         S_SET_CHK: begin
            if (rd_data_ff.value > val_ff) begin
               mem_we    = 1'b1;
               mem_wdata = '{known: rd_data_ff.known, low: rd_data_ff.low, value: val_ff};
               lvl_in    = lvl_ff + LVL_W'(1);
            end
         end
         S_ENC_RD: begin
            mem_re = 1'b1;
         end
         S_ENC_LOAD: begin
            low_in = low_max;
            nv_in  = rd_data_ff.value;
            nk_in  = rd_data_ff.known;
         end
         S_ENC_BIT: begin
            if (!stall) begin
               if (lt && !ge) low_in = low_ff + 6'd1;
               if (lt && ge) nk_in = 1'b1;
               if (want) begin
                  if (hold_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_item_in  = '{code_bit: hold_bit_ff, last_bit: 1'b0};
                  end
                  hold_v_in   = 1'b1;
                  hold_bit_in = emit_bit;
                  cnt_in      = cnt_ff + 6'd1;
               end
            end
         end
         S_ENC_WR: begin
            mem_we = 1'b1;
            if (lvl_ff != '0) lvl_in = lvl_ff - LVL_W'(1);
         end
         S_FLUSH: begin
            if (hold_v_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{code_bit: hold_bit_ff, last_bit: 1'b1};
               hold_v_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         grid_w_ff    <= DIM_W'(1);
         grid_h_ff    <= DIM_W'(1);
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH) grid_w_ff <= csr_wdata;
            else if (csr_index == CSR_GRID_HEIGHT) grid_h_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_item.cmd;
         leaf_ff <= req_item.leaf_index;
         val_ff  <= req_item.leaf_value;
         thr_ff  <= req_item.threshold;
      end
      lvl_ff      <= lvl_in;
      low_ff      <= low_in;
      nv_ff       <= nv_in;
      nk_ff       <= nk_in;
      hold_bit_ff <= hold_bit_in;
      cnt_ff      <= cnt_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) node_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= node_mem[mem_raddr];
   end

endmodule

// ===== tb/tag_tree_encoder_core_tb.sv =====
// Self-checking testbench for tag_tree_encoder_core: random and directed items,
// an in-bench tag tree model that predicts every code bit. Depends on ttenc_pkg.
module tag_tree_encoder_core_tb;
   import ttenc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_CAP = 2 * MAX_GRID_WIDTH * MAX_GRID_HEIGHT + 4 * MAX_GRID_WIDTH
                             + 4 * MAX_GRID_HEIGHT + 4 * MAX_LEVELS + 8;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 6000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [6:0]   csr_wdata;

   tag_tree_encoder_core u_top (.*);

   logic [9:0]   tree_value [NODE_CAP];
   logic [5:0]   tree_low [NODE_CAP];
   logic         tree_known [NODE_CAP];
   int           cfg_width;
   int           cfg_height;
   int           path_node [MAX_LEVELS];

   req_item_type pending_items [$];
   rsp_item_type expected_bits [$];
   int           error_count;
   bit           req_taken;
   int           req_gap;
   int           rsp_stall;
   bit           quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (quiet || r < 13) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_dim(int v, int max_v);
      if (v == 0) return 1;
      return (v > max_v) ? max_v : v;
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < NODE_CAP; i++) begin
         tree_value[i] = NODE_INIT;
         tree_low[i]   = '0;
         tree_known[i] = 1'b0;
      end
   endfunction

   function automatic int trace_path(int leaf);
      int w, h, x, y, base, n, idx;
      w = clamp_dim(cfg_width, MAX_GRID_WIDTH);
      h = clamp_dim(cfg_height, MAX_GRID_HEIGHT);
      base = 0;
      n = 0;
      if (leaf >= w * h) return 0;
      x = leaf % w;
      y = leaf / w;
      forever begin
         idx = base + y * w + x;
         if (idx >= NODE_CAP) break;
         path_node[n] = idx;
         n++;
         if ((w == 1 && h == 1) || n >= MAX_LEVELS) break;
         base += w * h;
         w = (w + 1) / 2;
         h = (h + 1) / 2;
         x /= 2;
         y /= 2;
      end
      return n;
   endfunction

   function automatic void push_bit(logic b, ref int count);
      rsp_item_type r;
      if (count < RESULT_CAP) begin
         r.code_bit = b;
         r.last_bit = 1'b0;
         expected_bits.push_back(r);
         count++;
      end
   endfunction

   function automatic void predict_code_bits(req_item_type it);
      int n, k, count, bound, thr;
      rsp_item_type r;
      count = 0;
      bound = 0;
      thr = it.threshold;
      if (it.cmd == CMD_CLEAR) begin
         clear_tree();
         return;
      end
      if (it.cmd != CMD_SET && it.cmd != CMD_ENCODE) return;
      n = trace_path(it.leaf_index);
      if (n == 0) return;
      if (it.cmd == CMD_SET) begin
         for (int i = 0; i < n; i++) begin
            if (tree_value[path_node[i]] <= it.leaf_value) break;
            tree_value[path_node[i]] = it.leaf_value;
         end
         return;
      end
      for (int i = n - 1; i >= 0; i--) begin
         k = path_node[i];
         if (bound < tree_low[k]) bound = tree_low[k];
         while (bound < thr) begin
            if (bound >= tree_value[k]) begin
               if (!tree_known[k]) begin
                  push_bit(1'b1, count);
                  tree_known[k] = 1'b1;
               end
               break;
            end
            push_bit(1'b0, count);
            bound++;
         end
         tree_low[k] = bound[5:0];
      end
      if (count > 0) begin
         r = expected_bits.pop_back();
         r.last_bit = 1'b1;
         expected_bits.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) predict_code_bits(req_item);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH) cfg_width = csr_wdata;
            else if (csr_index == CSR_GRID_HEIGHT) cfg_height = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bits.size() == 0) begin
               $error("unexpected item: code_bit %0d last_bit %0d",
                      rsp_item.code_bit, rsp_item.last_bit);
               error_count++;
            end else begin
               rsp_item_type e;
               e = expected_bits.pop_front();
               if (rsp_item.code_bit !== e.code_bit) begin
                  $error("code_bit expected %0d actual %0d", e.code_bit, rsp_item.code_bit);
                  error_count++;
               end
               if (rsp_item.last_bit !== e.last_bit) begin
                  $error("last_bit expected %0d actual %0d", e.last_bit, rsp_item.last_bit);
                  error_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_items.size() > 0) begin
         req_item  <= pending_items.pop_front();
         req_valid <= 1'b1;
         req_gap   <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= pick_gap();
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_item(logic [1:0] cmd, int leaf, int value, int thr);
      req_item_type it;
      it.cmd        = cmd;
      it.leaf_index = leaf[11:0];
      it.leaf_value = value[9:0];
      it.threshold  = thr[5:0];
      pending_items.push_back(it);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bits.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int w_reg, int h_reg, int count);
      int leaves, thr, r;
      leaves = clamp_dim(w_reg, MAX_GRID_WIDTH) * clamp_dim(h_reg, MAX_GRID_HEIGHT);
      write_csr(CSR_GRID_WIDTH, w_reg[6:0]);
      write_csr(CSR_GRID_HEIGHT, h_reg[6:0]);
      quiet = ($urandom_range(0, 3) == 0);
      add_item(CMD_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 1023), 0);
      thr = 0;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 38)
            add_item(CMD_SET, $urandom_range(0, leaves - 1),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 60), 0);
         else if (r < 88) begin
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                              : ((thr + $urandom_range(0, 6)) % 64);
            add_item(CMD_ENCODE, $urandom_range(0, leaves - 1), $urandom_range(0, 1023), thr);
         end else if (r < 94)
            add_item(($urandom_range(0, 1) == 0) ? CMD_SET : CMD_ENCODE,
                     $urandom_range(leaves, 4095),
                     $urandom_range(0, 1023), $urandom_range(0, 63));
         else if (r < 98)
            add_item(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 1023),
                     $urandom_range(0, 63));
         else
            add_item(CMD_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 1023),
                     $urandom_range(0, 63));
      end
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = CSR_GRID_WIDTH;
      csr_wdata   = '0;
      req_item    = '0;
      error_count = 0;
      quiet       = 1'b0;
      cfg_width   = 1;
      cfg_height  = 1;
      clear_tree();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_item(CMD_ENCODE, 0, 0, 63);
      add_item(CMD_SET, 0, 0, 0);
      add_item(CMD_ENCODE, 0, 0, 0);
      add_item(CMD_ENCODE, 0, 0, 63);
      add_item(CMD_ENCODE, 0, 0, 63);
      add_item(CMD_SET, 1, 5, 0);
      add_item(CMD_UNUSED, 4095, 1023, 63);
      add_item(CMD_CLEAR, 4095, 1023, 63);
      add_item(CMD_SET, 0, 998, 0);
      add_item(CMD_ENCODE, 0, 1023, 56);
      drain();

      write_csr(CSR_GRID_WIDTH, 7'd64);
      write_csr(CSR_GRID_HEIGHT, 7'd64);
      add_item(CMD_SET, 4095, 3, 0);
      add_item(CMD_SET, 0, 40, 0);
      add_item(CMD_ENCODE, 4095, 0, 63);
      add_item(CMD_ENCODE, 0, 0, 56);
      add_item(CMD_ENCODE, 4032, 0, 63);
      add_item(CMD_ENCODE, 63, 0, 20);
      drain();

      write_csr(CSR_GRID_WIDTH, 7'd0);
      write_csr(CSR_GRID_HEIGHT, 7'd127);
      add_item(CMD_SET, 63, 2, 0);
      add_item(CMD_ENCODE, 63, 0, 10);
      add_item(CMD_ENCODE, 64, 0, 10);
      drain();

      random_phase(1, 1, 35);
      random_phase(64, 64, 45);
      random_phase(5, 3, 45);
      random_phase(0, 127, 35);
      random_phase(127, 2, 35);
      random_phase($urandom_range(1, 64), $urandom_range(1, 64), 45);
      random_phase($urandom_range(0, 127), $urandom_range(0, 127), 40);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

endmodule
